// ----- hw/rtl/bitplane_to_chunky_pens_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bitplane to chunky pen core
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITPLANE_TO_CHUNKY_PENS_CORE_ASSERT_SVH
`define BITPLANE_TO_CHUNKY_PENS_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, constants and helpers shared by the bitplane to chunky pen core.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int MAX_PLANES = 8;
  localparam int MAX_WIDTH  = 4096;

  localparam logic [4:0]  GROUP_PIXELS = 5'd16;
  localparam logic [4:0]  CHUNK_PENS   = 5'd8;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_PLANE_COUNT = 2'd0;
  localparam logic [1:0] CFG_IDX_WIDTH       = 2'd1;
  localparam logic [1:0] CFG_IDX_HEIGHT      = 2'd2;

  typedef struct packed {
    logic [1:0]  plane_count_code;
    logic [12:0] width_px;
    logic [12:0] height_rows;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    plane_count_code: 2'd2,
    width_px:         13'd320,
    height_rows:      13'd200
  };

  typedef struct packed {
    logic [15:0] plane_word_0;
    logic [15:0] plane_word_1;
    logic [15:0] plane_word_2;
    logic [15:0] plane_word_3;
    logic [15:0] plane_word_4;
    logic [15:0] plane_word_5;
    logic [15:0] plane_word_6;
    logic [15:0] plane_word_7;
    logic [7:0]  group_index;
    logic [11:0] row_index;
    logic [3:0]  first_pixel;
    logic [4:0]  pixel_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] pens;
    logic [3:0]  pen_count;
    logic        last;
  } out_item_t;

  // After the decode stage
  typedef struct packed {
    logic [7:0][15:0] planes;
    logic [7:0]       plane_mask;
    logic [7:0]       group;
    logic [3:0]       first;
    logic [4:0]       run_end;
    logic             row_ok;
  } a_item_t;

  // After the pen gather stage: byte k holds the pen of pixel k
  typedef struct packed {
    logic [15:0][7:0] pens;
    logic [3:0]       first;
    logic [3:0]       lo_n;
    logic [3:0]       hi_n;
  } b_item_t;

  // After the alignment stage
  typedef struct packed {
    logic [63:0] lo_pens;
    logic [63:0] hi_pens;
    logic [3:0]  lo_n;
    logic [3:0]  hi_n;
  } c_item_t;

  typedef enum logic {
    SEL_LO,
    SEL_HI
  } chunk_sel_t;

  // Planes that contribute: 1 << code of them, never more than max_planes.
  function automatic logic [7:0] plane_mask_of(input logic [1:0] code, input int max_planes);
    logic [7:0] m;
    m = '0;
    for (int p = 0; p < 8; p++) begin
      m[p] = (p < (1 << code)) && (p < max_planes);
    end
    return m;
  endfunction

endpackage

// ----- hw/rtl/bpc_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_in_stage
// Input register: works out the run end, row check and plane mask.
// ----------------------------------------------------------------------------
module bpc_in_stage #(
  parameter int MAX_PLANES = bpc_pkg::MAX_PLANES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bpc_pkg::cfg_t     cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  bpc_pkg::in_item_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output bpc_pkg::a_item_t  dn_data
);

  logic             v_r;
  bpc_pkg::a_item_t d_r;
  bpc_pkg::a_item_t d_nxt;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_comb begin
    logic [5:0] sum;
    sum = {2'b00, up_data.first_pixel} + {1'b0, up_data.pixel_count};
    d_nxt.planes = {up_data.plane_word_7, up_data.plane_word_6,
                    up_data.plane_word_5, up_data.plane_word_4,
                    up_data.plane_word_3, up_data.plane_word_2,
                    up_data.plane_word_1, up_data.plane_word_0};
    d_nxt.plane_mask = bpc_pkg::plane_mask_of(cfg.plane_count_code, MAX_PLANES);
    d_nxt.group      = up_data.group_index;
    d_nxt.first      = up_data.first_pixel;
    // A run that passes the group end is cut there.
    d_nxt.run_end    = (sum > {1'b0, bpc_pkg::GROUP_PIXELS}) ? bpc_pkg::GROUP_PIXELS
                                                             : sum[4:0];
    d_nxt.row_ok     = {1'b0, up_data.row_index} < cfg.height_rows;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ----- hw/rtl/bpc_pen_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pen_stage
// Gathers sixteen pens, blanks those outside the run or the surface.
// ----------------------------------------------------------------------------
module bpc_pen_stage #(
  parameter int MAX_WIDTH = bpc_pkg::MAX_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bpc_pkg::cfg_t    cfg,
  input  logic             up_valid,
  output logic             up_ready,
  input  bpc_pkg::a_item_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output bpc_pkg::b_item_t dn_data
);

  localparam logic [16:0] MAX_WIDTH_W = 17'(MAX_WIDTH);

  logic             v_r;
  bpc_pkg::b_item_t d_r;
  bpc_pkg::b_item_t d_nxt;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_comb begin
    logic [7:0]  pen;
    logic [11:0] x;
    logic        in_run;
    logic        x_ok;
    logic [4:0]  lo_start;
    logic [4:0]  lo_end;
    logic [4:0]  hi_start;
    for (int k = 0; k < 16; k++) begin
      for (int p = 0; p < 8; p++) begin
        pen[p] = up_data.planes[3'(p)][4'(15 - k)] & up_data.plane_mask[p];
      end
      x      = {up_data.group, 4'(k)};
      in_run = (5'(k) >= {1'b0, up_data.first}) && (5'(k) < up_data.run_end);
      x_ok   = ({5'b0, x} < {4'b0, cfg.width_px}) &&
               ({5'b0, x} < MAX_WIDTH_W);
      d_nxt.pens[k] = (in_run && x_ok && up_data.row_ok) ? pen : 8'h00;
    end

    // Pens of the run in each half of the group
    lo_start = up_data.first[3] ? bpc_pkg::CHUNK_PENS : {1'b0, up_data.first};
    lo_end   = (up_data.run_end > bpc_pkg::CHUNK_PENS) ? bpc_pkg::CHUNK_PENS
                                                       : up_data.run_end;
    hi_start = up_data.first[3] ? {1'b0, up_data.first} : bpc_pkg::CHUNK_PENS;
    d_nxt.lo_n  = (lo_end > lo_start) ? 4'(lo_end - lo_start) : 4'd0;
    d_nxt.hi_n  = (up_data.run_end > hi_start) ? 4'(up_data.run_end - hi_start) : 4'd0;
    d_nxt.first = up_data.first;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ----- hw/rtl/bpc_align_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_align_stage
// Shifts each half so that its first wanted pen lands in the lowest byte.
// ----------------------------------------------------------------------------
module bpc_align_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  bpc_pkg::b_item_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output bpc_pkg::c_item_t dn_data
);

  logic             v_r;
  logic             has_pens;
  bpc_pkg::c_item_t d_r;
  bpc_pkg::c_item_t d_nxt;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  // An item with an empty run produces nothing and is dropped here.
  assign has_pens = (up_data.lo_n != 4'd0) || (up_data.hi_n != 4'd0);

  always_comb begin
    logic [5:0] hi_shift;
    hi_shift      = up_data.first[3] ? {up_data.first[2:0], 3'b000} : 6'd0;
    d_nxt.lo_pens = 64'(up_data.pens[7:0]) >> {up_data.first[2:0], 3'b000};
    d_nxt.hi_pens = 64'(up_data.pens[15:8]) >> hi_shift;
    d_nxt.lo_n    = up_data.lo_n;
    d_nxt.hi_n    = up_data.hi_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid && has_pens;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ----- hw/rtl/bpc_chunk_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_chunk_out
// Output register: presents the low and then the high chunk of an item, skipping a half with no pens.
// ----------------------------------------------------------------------------
module bpc_chunk_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  bpc_pkg::c_item_t   up_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bpc_pkg::out_item_t out_data
);

  logic                v_r;
  logic                v_nxt;
  bpc_pkg::chunk_sel_t sel_r;
  bpc_pkg::chunk_sel_t sel_nxt;
  bpc_pkg::c_item_t    d_r;
  logic                show_last;
  logic                load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      sel_r <= bpc_pkg::SEL_LO;
    end else begin
      v_r   <= v_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_comb begin
    show_last = (sel_r == bpc_pkg::SEL_HI) || (d_r.hi_n == 4'd0);
    // A new item may enter in the cycle the final chunk of the old one leaves.
    up_ready  = !v_r || (out_ready && show_last);
    load      = up_valid && up_ready;
    v_nxt     = v_r;
    sel_nxt   = sel_r;
    if (load) begin
      v_nxt   = 1'b1;
      sel_nxt = (up_data.lo_n == 4'd0) ? bpc_pkg::SEL_HI : bpc_pkg::SEL_LO;
    end else if (v_r && out_ready) begin
      if (show_last) begin
        v_nxt = 1'b0;
      end else begin
        sel_nxt = bpc_pkg::SEL_HI;
      end
    end

    out_valid = v_r;
    case (sel_r)
      bpc_pkg::SEL_LO: begin
        out_data.pens      = d_r.lo_pens;
        out_data.pen_count = d_r.lo_n;
      end
      bpc_pkg::SEL_HI: begin
        out_data.pens      = d_r.hi_pens;
        out_data.pen_count = d_r.hi_n;
      end
      default: begin
        out_data.pens      = d_r.hi_pens;
        out_data.pen_count = d_r.hi_n;
      end
    endcase
    out_data.last = show_last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r <= up_data;
    end
  end

endmodule

// ----- hw/rtl/bitplane_to_chunky_pens_core.sv -----
`timescale 1ns / 1ps
// The first chunk of an item passes the input, pen gather and alignment registers into the output register.
// Throughput: one item per cycle for one-chunk items while out_ready is high; an item
// whose run spans both halves of the group holds the output register until both chunks leave.
// Reset (synchronous, rst_n low) empties every stage and loads the register defaults:
// four planes, width 320, height 200. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
// bitplane_to_chunky_pens_core
// Converts one group of interleaved plane words into chunks of eight-bit pens.
// ----------------------------------------------------------------------------
module bitplane_to_chunky_pens_core #(
  parameter int MAX_PLANES = bpc_pkg::MAX_PLANES,
  parameter int MAX_WIDTH  = bpc_pkg::MAX_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bpc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bpc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);

  bpc_pkg::cfg_t    cfg_r;
  bpc_pkg::cfg_t    cfg_nxt;

  logic             a_valid;
  logic             a_ready;
  bpc_pkg::a_item_t a_data;
  logic             b_valid;
  logic             b_ready;
  bpc_pkg::b_item_t b_data;
  logic             c_valid;
  logic             c_ready;
  bpc_pkg::c_item_t c_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpc_pkg::CFG_IDX_PLANE_COUNT: cfg_nxt.plane_count_code = cfg_data[1:0];
        bpc_pkg::CFG_IDX_WIDTH:       cfg_nxt.width_px         = cfg_data;
        bpc_pkg::CFG_IDX_HEIGHT:      cfg_nxt.height_rows      = cfg_data;
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= bpc_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bpc_in_stage #(
    .MAX_PLANES (MAX_PLANES)
  ) u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (a_valid),
    .dn_ready (a_ready),
    .dn_data  (a_data)
  );

  bpc_pen_stage #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pen (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (a_valid),
    .up_ready (a_ready),
    .up_data  (a_data),
    .dn_valid (b_valid),
    .dn_ready (b_ready),
    .dn_data  (b_data)
  );

  bpc_align_stage u_align (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (b_valid),
    .up_ready (b_ready),
    .up_data  (b_data),
    .dn_valid (c_valid),
    .dn_ready (c_ready),
    .dn_data  (c_data)
  );

  bpc_chunk_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (c_valid),
    .up_ready  (c_ready),
    .up_data   (c_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/bpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks on the result channel of the pen core.
// ----------------------------------------------------------------------------
`include "bitplane_to_chunky_pens_core_assert.svh"

module bpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input bpc_pkg::out_item_t out_data
);

  `BPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `BPC_ASSERT_NOW(a_count_range, out_valid, (out_data.pen_count >= 4'd1) && (out_data.pen_count <= 4'd8), "pen count out of range")
  `BPC_ASSERT_NOW(a_unused_zero, out_valid, (out_data.pens >> {out_data.pen_count, 3'b000}) == 64'd0, "bytes past pen count not zero")
  `BPC_ASSERT_NEXT(a_second_chunk, out_valid && out_ready && !out_data.last, out_valid && out_data.last, "second chunk did not follow")

endmodule

bind bitplane_to_chunky_pens_core bpc_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- bench/bpc_pen_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pen_checker
// Watches the configuration, group and chunk channels of the bitplane to
// chunky pen core. It keeps its own copy of the surface registers, works out
// the pen chunks that each accepted group should give and compares every
// accepted chunk, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module bpc_pen_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  bpc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  bpc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  output int                 chunks_pending,
  output int                 mismatch_count
);

  bpc_pkg::cfg_t      surface_cfg;
  bpc_pkg::out_item_t owed_chunks [$];

  // Splits the wanted run of a group at pixel 8 and queues one chunk for each half that the run touches.
  task automatic predict_chunks(input bpc_pkg::in_item_t grp);
    logic [7:0][15:0]   words;
    logic [63:0]        pens;
    logic [7:0]         pen;
    bpc_pkg::out_item_t chunk;
    int                 planes;
    int                 width_lim;
    int                 run_end;
    int                 half_end;
    int                 stop_px;
    int                 px;
    int                 n;
    int                 x;
    words[0] = grp.plane_word_0;
    words[1] = grp.plane_word_1;
    words[2] = grp.plane_word_2;
    words[3] = grp.plane_word_3;
    words[4] = grp.plane_word_4;
    words[5] = grp.plane_word_5;
    words[6] = grp.plane_word_6;
    words[7] = grp.plane_word_7;
    planes = 1 << surface_cfg.plane_count_code;
    if (planes > bpc_pkg::MAX_PLANES) planes = bpc_pkg::MAX_PLANES;
    width_lim = int'(surface_cfg.width_px);
    if (width_lim > bpc_pkg::MAX_WIDTH) width_lim = bpc_pkg::MAX_WIDTH;
    if (grp.pixel_count == 0) return;
    run_end = int'(grp.first_pixel) + int'(grp.pixel_count);
    if (run_end > 16) run_end = 16;
    px = int'(grp.first_pixel);
    while (px < run_end) begin
      half_end = (px < 8) ? 8 : 16;
      stop_px  = (run_end < half_end) ? run_end : half_end;
      pens = '0;
      n    = 0;
      while (px < stop_px) begin
        x   = int'(grp.group_index) * 16 + px;
        pen = '0;
        if (x < width_lim && int'(grp.row_index) < int'(surface_cfg.height_rows)) begin
          for (int p = 0; p < 8; p++) begin
            if (p < planes && words[p][15 - px]) pen[p] = 1'b1;
          end
        end
        pens = pens | (64'(pen) << (8 * n));
        px++;
        n++;
      end
      chunk.pens      = pens;
      chunk.pen_count = 4'(n);
      chunk.last      = (px >= run_end);
      owed_chunks.push_back(chunk);
    end
  endtask

  always @(posedge clk) begin
    bpc_pkg::out_item_t want;
    if (!rst_n) begin
      surface_cfg = bpc_pkg::CFG_RESET;
      owed_chunks.delete();
    end else begin
      // A group accepted together with a register write still sees the old setting.
      if (in_valid && in_ready) predict_chunks(in_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bpc_pkg::CFG_IDX_PLANE_COUNT: surface_cfg.plane_count_code = cfg_data[1:0];
          bpc_pkg::CFG_IDX_WIDTH:       surface_cfg.width_px         = cfg_data;
          bpc_pkg::CFG_IDX_HEIGHT:      surface_cfg.height_rows      = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_chunks.size() == 0) begin
          $error("chunk with none owed: pens %h, pen_count %0d, last %0d",
                 out_data.pens, out_data.pen_count, out_data.last);
          mismatch_count++;
        end else begin
          want = owed_chunks.pop_front();
          if (out_data.pens !== want.pens) begin
            $error("pens: expected %h, got %h", want.pens, out_data.pens);
            mismatch_count++;
          end
          if (out_data.pen_count !== want.pen_count) begin
            $error("pen_count: expected %0d, got %0d", want.pen_count, out_data.pen_count);
            mismatch_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            mismatch_count++;
          end
        end
      end
    end
    // Registered for the stimulus, so it never reads empty too early.
    chunks_pending <= owed_chunks.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the bitplane to chunky pen core: a directed set of groups on
// the reset surface, then phases of random groups, each on a new surface
// setting, with random gaps on both channels, quiet phases, two long holds on
// the chunk side and a full drain in mid run. The checker beside the core
// does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int                 NUM_PHASES       = 9;
  localparam int                 GROUPS_PER_PHASE = 174;
  localparam int                 SETTLE_CYCLES    = 8;
  localparam int                 LONG_HOLD        = 80;
  localparam int                 STALL_LIMIT      = 2000;
  localparam logic [1:0]         CFG_IDX_SPARE    = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  bpc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bpc_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [12:0]        cfg_data = '0;

  int chunks_pending;
  int mismatch_count;
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;

  bitplane_to_chunky_pens_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bpc_pen_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .chunks_pending (chunks_pending),
    .mismatch_count (mismatch_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Ends the run if no item moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Chunk side: a random hold before each item, and two long holds by count.
  initial begin : chunk_sink
    int gap;
    int taken;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 150 || taken == 1100) gap = LONG_HOLD;
      else if (quiet_phase) gap = 0;
      else gap = $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  function automatic bpc_pkg::in_item_t pack_group(input logic [7:0][15:0] w,
                                                   input logic [7:0] grp_idx,
                                                   input logic [11:0] row,
                                                   input logic [3:0] first,
                                                   input logic [4:0] count);
    bpc_pkg::in_item_t it;
    it.plane_word_0 = w[0];
    it.plane_word_1 = w[1];
    it.plane_word_2 = w[2];
    it.plane_word_3 = w[3];
    it.plane_word_4 = w[4];
    it.plane_word_5 = w[5];
    it.plane_word_6 = w[6];
    it.plane_word_7 = w[7];
    it.group_index  = grp_idx;
    it.row_index    = row;
    it.first_pixel  = first;
    it.pixel_count  = count;
    return it;
  endfunction

  // Each plane gets the seed pattern rotated by its plane number.
  function automatic bpc_pkg::in_item_t directed_group(input logic [15:0] seed,
                                                       input logic [7:0] grp_idx,
                                                       input logic [11:0] row,
                                                       input logic [3:0] first,
                                                       input logic [4:0] count);
    logic [7:0][15:0] w;
    for (int p = 0; p < 8; p++) w[p] = (seed << p) | (seed >> (16 - p));
    return pack_group(w, grp_idx, row, first, count);
  endfunction

  // Mostly runs that fit the group on or near the visible surface; the rest
  // are overlong runs, empty runs and groups anywhere.
  function automatic bpc_pkg::in_item_t random_group(input int width, input int height);
    logic [7:0][15:0] w;
    logic [7:0]       grp_idx;
    logic [11:0]      row;
    logic [3:0]       first;
    logic [4:0]       count;
    int               top_group;
    int               top_row;
    int               pick;
    for (int p = 0; p < 8; p++) w[p] = 16'($urandom);
    top_group = (width + 15) / 16;
    if (top_group > 255) top_group = 255;
    top_row = (height > 4095) ? 4095 : height;
    grp_idx = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, top_group))
                                         : 8'($urandom_range(0, 255));
    row = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, top_row))
                                     : 12'($urandom_range(0, 4095));
    first = 4'($urandom_range(0, 15));
    pick  = $urandom_range(0, 19);
    if (pick < 14) count = 5'($urandom_range(1, 16 - int'(first)));
    else if (pick < 19) count = 5'($urandom_range(1, 31));
    else count = 5'd0;
    return pack_group(w, grp_idx, row, first, count);
  endfunction

  task automatic offer_group(input bpc_pkg::in_item_t grp);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= grp;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering until every owed chunk is in, then lets an empty-run item
  // still inside the pipeline pass out of it.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chunks_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_surface(input logic [1:0] code, input logic [12:0] width,
                                 input logic [12:0] height, input bit touch_spare);
    write_register(bpc_pkg::CFG_IDX_PLANE_COUNT, 13'(code));
    write_register(bpc_pkg::CFG_IDX_WIDTH, width);
    write_register(bpc_pkg::CFG_IDX_HEIGHT, height);
    if (touch_spare) write_register(CFG_IDX_SPARE, 13'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int                phase_code   [NUM_PHASES];
    int                phase_width  [NUM_PHASES];
    int                phase_height [NUM_PHASES];
    int                produced;
    bpc_pkg::in_item_t grp;
    phase_code   = '{2, 0, 3, 1, 3, 2, 0, 3, 0};
    phase_width  = '{320, 1, 4096, 8191, 0, 17, 0, 4095, 0};
    phase_height = '{200, 1, 4096, 8191, 4095, 0, 0, 1, 0};
    phase_code[6]   = $urandom_range(0, 3);
    phase_width[6]  = $urandom_range(1, 700);
    phase_height[6] = $urandom_range(1, 500);
    phase_code[8]   = $urandom_range(0, 3);
    phase_width[8]  = $urandom_range(0, 8191);
    phase_height[8] = $urandom_range(0, 8191);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset surface: four planes, 320 by 200.
    offer_group(directed_group(16'hffff, 8'd0,   12'd0,    4'd0,  5'd16));
    offer_group(directed_group(16'h0000, 8'd0,   12'd0,    4'd0,  5'd16));
    offer_group(directed_group(16'h8001, 8'd1,   12'd1,    4'd15, 5'd1));
    offer_group(directed_group(16'ha5c3, 8'd2,   12'd2,    4'd0,  5'd8));
    offer_group(directed_group(16'ha5c3, 8'd3,   12'd3,    4'd8,  5'd8));
    offer_group(directed_group(16'h1234, 8'd4,   12'd4,    4'd7,  5'd2));
    offer_group(directed_group(16'hf0f0, 8'd5,   12'd5,    4'd10, 5'd16));
    offer_group(directed_group(16'hffff, 8'd6,   12'd6,    4'd0,  5'd31));
    offer_group(directed_group(16'hffff, 8'd7,   12'd7,    4'd3,  5'd0));
    offer_group(directed_group(16'hffff, 8'd19,  12'd199,  4'd0,  5'd16));
    offer_group(directed_group(16'hffff, 8'd20,  12'd10,   4'd0,  5'd16));
    offer_group(directed_group(16'hffff, 8'd255, 12'd0,    4'd15, 5'd17));
    offer_group(directed_group(16'hffff, 8'd1,   12'd200,  4'd0,  5'd16));
    offer_group(directed_group(16'hffff, 8'd1,   12'd4095, 4'd4,  5'd4));
    offer_group(directed_group(16'h5555, 8'd0,   12'd0,    4'd1,  5'd15));
    offer_group(directed_group(16'haaaa, 8'd12,  12'd100,  4'd8,  5'd1));
    offer_group(directed_group(16'h0f0f, 8'd19,  12'd0,    4'd12, 5'd31));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_for_drain();
      quiet_phase = (ph == 2 || ph == 6);
      program_surface(2'(phase_code[ph]), 13'(phase_width[ph]), 13'(phase_height[ph]),
                      (ph == 0 || ph == 8));
      produced = 0;
      while (produced < GROUPS_PER_PHASE) begin
        if (ph == 3 && produced == 90) wait_for_drain();
        grp = random_group(phase_width[ph], phase_height[ph]);
        offer_group(grp);
        if (grp.pixel_count != 0) produced++;
      end
    end

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
